>>> src/hlb_pkg.sv
// Package for the HRD leaky bucket model: widths, register indexes, reset values.
`timescale 1ns / 1ps
package hlb_pkg;

  // Unit quantities (bits times frame rate numerator).
  localparam int UnitW = 48;
  localparam int CntW  = 32;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegBufSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBitRate = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFpsNum  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFpsDen  = 2'd3;

  // Register reset values.
  localparam logic [31:0] BufSizeRst = 32'd1048576;
  localparam logic [31:0] BitRateRst = 32'd524288;
  localparam logic [15:0] FpsNumRst  = 16'd30;
  localparam logic [15:0] FpsDenRst  = 16'd1;

  // Iteration counts of the shared divider.
  localparam int StepCntW  = 6;
  localparam int FullSteps = 8;
  localparam int QuoSteps  = UnitW;

  // Largest fullness code.
  localparam logic [7:0] CodeMax = 8'd255;

  // Saturating increment of a 32-bit counter.
  function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v);
    inc_sat = (v == '1) ? v : v + CntW'(1);
  endfunction

endpackage

>>> src/hrd_leaky_bucket_model.sv
// HRD leaky bucket model: sequencer around one multiplier and one subtractor.
// Steps from input beat to result beat: 3 multiplies, 4 level steps, two fullness
//   divides, a divide by the frame rate numerator and 1 output load.
//   A new picture is taken only once the last one is done; in_stall_o is high until then.
// Reset: async active low; registers return to defaults, statistics clear,
//   the lowest level reads all ones and the first-picture flag is set.
`timescale 1ns / 1ps
module hrd_leaky_bucket_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [hlb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // picture commit channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] picture_size_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        underflow_o,
  output logic        paused_o,
  output logic [7:0]  this_fullness_code_o,
  output logic [47:0] after_level_o,
  output logic [7:0]  next_fullness_code_o,
  output logic [31:0] next_max_picture_o,
  output logic [31:0] frame_count_o,
  output logic [47:0] bits_total_o,
  output logic [31:0] pause_count_o,
  output logic [31:0] underflow_count_o,
  output logic [47:0] lowest_after_o,
  output logic [47:0] highest_pre_o
);

  localparam int UW = hlb_pkg::UnitW;
  localparam int CW = hlb_pkg::CntW;
  localparam int SW = hlb_pkg::StepCntW;

  // Sequencer codes
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SMBuf = 4'd1;
  localparam logic [3:0] SMRef = 4'd2;
  localparam logic [3:0] SMPic = 4'd3;
  localparam logic [3:0] SInit = 4'd4;
  localparam logic [3:0] SPre  = 4'd5;
  localparam logic [3:0] SUpd  = 4'd6;
  localparam logic [3:0] SNPre = 4'd7;
  localparam logic [3:0] SFLd  = 4'd8;
  localparam logic [3:0] SFIt  = 4'd9;
  localparam logic [3:0] SFEnd = 4'd10;
  localparam logic [3:0] SQLd  = 4'd11;
  localparam logic [3:0] SQIt  = 4'd12;
  localparam logic [3:0] SQEnd = 4'd13;
  localparam logic [3:0] SOut  = 4'd14;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [31:0] bsb_q, br_q;
  logic [15:0] num_q, den_q;

  // Persistent bucket state and statistics
  logic          first_q;
  logic [UW-1:0] level_q, min_q, max_q, sum_q;
  logic [CW-1:0] frames_q, pauses_q, unders_q;

  // Per-picture working registers
  logic [31:0]   pic_q;
  logic [UW-1:0] buf_q, refill_q, picu_q, init_q, pre_q, npre_q;
  logic          clip_q, under_q;
  logic          fsel_q, fzero_q, fge_q;
  logic [UW-1:0] rem_q, quo_q;
  logic [SW-1:0] cnt_q;
  logic [7:0]    tcode_q, ncode_q;
  logic [31:0]   nmax_q;

  // Output register
  logic          out_valid_q;
  logic          o_under_q, o_paused_q;
  logic [7:0]    o_tcode_q, o_ncode_q;
  logic [UW-1:0] o_after_q, o_sum_q, o_min_q, o_max_q;
  logic [31:0]   o_nmax_q;
  logic [CW-1:0] o_frames_q, o_pauses_q, o_unders_q;

  logic in_acc, out_acc;
  assign in_stall_o  = (state_q != SIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  // registers only change between pictures
  assign cfg_ready_o = (state_q == SIdle);

  // Shared multiplier: 32 x 16, product fits the unit width
  logic [31:0]   mul_a;
  logic [15:0]   mul_b;
  logic [UW-1:0] mul_p;
  always_comb begin
    unique case (state_q)
      SMBuf: begin
        mul_a = bsb_q;
        mul_b = num_q;
      end
      SMRef: begin
        mul_a = br_q;
        mul_b = den_q;
      end
      SMPic: begin
        mul_a = pic_q;
        mul_b = num_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = UW'(mul_a) * UW'(mul_b);

  // Shared subtractor / comparator
  logic [UW:0]   sub_a, sub_b;
  logic [UW+1:0] sub_diff;
  logic          sub_ge;
  logic [UW-1:0] fval, r2q;
  assign fval = fsel_q ? npre_q : pre_q;
  assign r2q  = {rem_q[UW-2:0], quo_q[UW-1]};
  always_comb begin
    unique case (state_q)
      SUpd: begin
        sub_a = {1'b0, pre_q};
        sub_b = {1'b0, picu_q};
      end
      SFLd: begin
        sub_a = {1'b0, fval};
        sub_b = {1'b0, buf_q};
      end
      SFIt: begin
        sub_a = {rem_q, 1'b0};
        sub_b = {1'b0, buf_q};
      end
      SQIt: begin
        sub_a = {1'b0, r2q};
        sub_b = (UW+1)'(num_q);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[UW+1];

  // Level the next picture sees: refill added, clipped to the buffer; the initial level while no picture was accepted
  logic [UW:0]   seen_sum, init_sum;
  logic          seen_over;
  logic [UW-1:0] seen_pre, init_val;
  logic          seen_clip;
  assign seen_sum  = {1'b0, level_q} + {1'b0, refill_q};
  assign seen_over = seen_sum > {1'b0, buf_q};
  assign seen_pre  = first_q ? init_q : (seen_over ? buf_q : seen_sum[UW-1:0]);
  assign seen_clip = !first_q && seen_over && (refill_q != '0);

  // Initial level: half buffer plus one refill, clipped to the buffer
  assign init_sum = {1'b0, 1'b0, buf_q[UW-1:1]} + {1'b0, refill_q};
  assign init_val = (init_sum > {1'b0, buf_q}) ? buf_q : init_sum[UW-1:0];

  // Accepted-picture statistics
  logic [UW:0]   sum_ext;
  logic [UW-1:0] sum_sat;
  assign sum_ext = {1'b0, sum_q} + (UW+1)'(pic_q);
  assign sum_sat = sum_ext[UW] ? '1 : sum_ext[UW-1:0];

  // Fullness code from the divider result
  logic [8:0] code9;
  logic [7:0] fcode;
  assign code9 = {1'b0, quo_q[7:0]} + 9'(rem_q != '0) - 9'd1;
  assign fcode = fzero_q ? 8'd0 : (fge_q ? hlb_pkg::CodeMax : code9[7:0]);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_acc) state_d = SMBuf;
      SMBuf: state_d = SMRef;
      SMRef: state_d = SMPic;
      SMPic: state_d = SInit;
      SInit: state_d = SPre;
      SPre:  state_d = SUpd;
      SUpd:  state_d = SNPre;
      SNPre: state_d = SFLd;
      SFLd:  state_d = SFIt;
      SFIt:  if (cnt_q == SW'(hlb_pkg::FullSteps - 1)) state_d = SFEnd;
      SFEnd: state_d = fsel_q ? SQLd : SFLd;
      SQLd:  state_d = SQIt;
      SQIt:  if (cnt_q == SW'(hlb_pkg::QuoSteps - 1)) state_d = SQEnd;
      SQEnd: state_d = SOut;
      SOut:  if (!out_valid_q || !out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Control state, configuration and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      bsb_q       <= hlb_pkg::BufSizeRst;
      br_q        <= hlb_pkg::BitRateRst;
      num_q       <= hlb_pkg::FpsNumRst;
      den_q       <= hlb_pkg::FpsDenRst;
      first_q     <= 1'b1;
      level_q     <= '0;
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      frames_q    <= '0;
      pauses_q    <= '0;
      unders_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          hlb_pkg::RegBufSize: bsb_q <= cfg_data_i;
          hlb_pkg::RegBitRate: br_q  <= cfg_data_i;
          hlb_pkg::RegFpsNum:  num_q <= cfg_data_i[15:0];
          hlb_pkg::RegFpsDen:  den_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == SPre && seen_clip) pauses_q <= hlb_pkg::inc_sat(pauses_q);
      if (state_q == SUpd) begin
        if (!sub_ge) begin
          unders_q <= hlb_pkg::inc_sat(unders_q);
        end else begin
          level_q  <= sub_diff[UW-1:0];
          if (sub_diff[UW-1:0] < min_q) min_q <= sub_diff[UW-1:0];
          if (pre_q > max_q) max_q <= pre_q;
          sum_q    <= sum_sat;
          frames_q <= hlb_pkg::inc_sat(frames_q);
          first_q  <= 1'b0;
        end
      end
      if (state_q == SOut && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: if (in_acc) pic_q <= picture_size_i;
      SMBuf: buf_q    <= mul_p;
      SMRef: refill_q <= mul_p;
      SMPic: picu_q   <= mul_p;
      SInit: init_q   <= init_val;
      SPre: begin
        pre_q  <= seen_pre;
        clip_q <= seen_clip;
      end
      SUpd: under_q <= !sub_ge;
      SNPre: begin
        npre_q <= seen_pre;
        fsel_q <= 1'b0;
      end
      SFLd: begin
        rem_q   <= fval;
        fge_q   <= sub_ge;
        fzero_q <= (fval == '0) || (buf_q == '0);
        cnt_q   <= '0;
      end
      SFIt: begin
        rem_q <= sub_ge ? sub_diff[UW-1:0] : sub_a[UW-1:0];
        quo_q <= {quo_q[UW-2:0], sub_ge};
        cnt_q <= cnt_q + SW'(1);
      end
      SFEnd: begin
        if (fsel_q) ncode_q <= fcode;
        else tcode_q <= fcode;
        fsel_q <= 1'b1;
      end
      SQLd: begin
        quo_q <= npre_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      SQIt: begin
        rem_q <= sub_ge ? sub_diff[UW-1:0] : r2q;
        quo_q <= {quo_q[UW-2:0], sub_ge};
        cnt_q <= cnt_q + SW'(1);
      end
      SQEnd: nmax_q <= (num_q == '0) ? 32'd0 : quo_q[31:0];
      default: ;
    endcase
  end

  // Output register load
  always_ff @(posedge clk_i) begin
    if (state_q == SOut && (!out_valid_q || !out_stall_i)) begin
      o_under_q  <= under_q;
      o_paused_q <= clip_q;
      o_tcode_q  <= tcode_q;
      o_after_q  <= level_q;
      o_ncode_q  <= ncode_q;
      o_nmax_q   <= nmax_q;
      o_frames_q <= frames_q;
      o_sum_q    <= sum_q;
      o_pauses_q <= pauses_q;
      o_unders_q <= unders_q;
      o_min_q    <= min_q;
      o_max_q    <= max_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign underflow_o          = o_under_q;
  assign paused_o             = o_paused_q;
  assign this_fullness_code_o = o_tcode_q;
  assign after_level_o        = o_after_q;
  assign next_fullness_code_o = o_ncode_q;
  assign next_max_picture_o   = o_nmax_q;
  assign frame_count_o        = o_frames_q;
  assign bits_total_o         = o_sum_q;
  assign pause_count_o        = o_pauses_q;
  assign underflow_count_o    = o_unders_q;
  assign lowest_after_o       = o_min_q;
  assign highest_pre_o        = o_max_q;

  // Checks
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == SOut))
    else $error("result beat raised outside output load");

  a_pre_in_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SUpd) |-> (pre_q <= buf_q))
    else $error("pre-removal level above buffer");

  a_min_le_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !underflow_o |-> (lowest_after_o <= after_level_o))
    else $error("lowest level above current level on accepted picture");

endmodule

>>> sim/hrd_leaky_bucket_model_test.sv
// Self-checking testbench for the HRD leaky bucket decoder buffer model.
`timescale 1ns / 1ps
module hrd_leaky_bucket_model_test;
  import hlb_pkg::*;

  localparam int unsigned RandomPictures = 1900;
  localparam int unsigned QuietLimit     = 5000;
  localparam int unsigned SettleCycles   = 100;
  localparam int unsigned PrintCap       = 30;
  localparam logic [47:0] UnitMax        = 48'hFFFF_FFFF_FFFF;

  // One result beat of the block.
  typedef struct packed {
    logic        underflow;
    logic        paused;
    logic [7:0]  this_code;
    logic [47:0] after_level;
    logic [7:0]  next_code;
    logic [31:0] next_max;
    logic [31:0] frame_count;
    logic [47:0] bits_total;
    logic [31:0] pause_count;
    logic [31:0] underflow_count;
    logic [47:0] lowest_after;
    logic [47:0] highest_pre;
  } bucket_result_t;

  // Buffer occupancy predictor plus the queue of results the block owes it.
  class bucket_scoreboard;
    logic [31:0]    buf_size;
    logic [31:0]    rate;
    logic [15:0]    fps_num;
    logic [15:0]    fps_den;
    logic           first_pending;
    logic [47:0]    level_after;
    logic [47:0]    min_level;
    logic [47:0]    max_level;
    logic [47:0]    sum_bits;
    logic [31:0]    frames;
    logic [31:0]    pauses;
    logic [31:0]    rejects;
    logic [31:0]    max_hint;
    bucket_result_t bucket_reports_q[$];
    int unsigned    mismatches;
    int unsigned    n_results;
    int unsigned    n_rejected;
    int unsigned    n_clipped;

    function new();
      buf_size      = BufSizeRst;
      rate          = BitRateRst;
      fps_num       = FpsNumRst;
      fps_den       = FpsDenRst;
      first_pending = 1'b1;
      level_after   = '0;
      min_level     = UnitMax;
      max_level     = '0;
      sum_bits      = '0;
      frames        = '0;
      pauses        = '0;
      rejects       = '0;
      max_hint      = '0;
      mismatches    = 0;
      n_results     = 0;
      n_rejected    = 0;
      n_clipped     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        RegBufSize: buf_size = data;
        RegBitRate: rate     = data;
        RegFpsNum:  fps_num  = data[15:0];
        RegFpsDen:  fps_den  = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [47:0] clip_units(logic [63:0] v);
      return (v > {16'd0, UnitMax}) ? UnitMax : v[47:0];
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    // ceil(level*256/cap) held to 1..256, minus one; zero level or cap gives 0
    function logic [7:0] code_of(logic [47:0] lvl, logic [47:0] cap);
      logic [63:0] q;
      if (lvl == '0 || cap == '0) return 8'd0;
      q = ({16'd0, lvl} * 64'd256 + {16'd0, cap} - 64'd1) / {16'd0, cap};
      if (q < 64'd1) q = 64'd1;
      if (q > 64'd256) q = 64'd256;
      return 8'(q - 64'd1);
    endfunction

    // level a picture sees; refill beyond the headroom is a clip
    function logic [47:0] level_for(logic [47:0] cap, logic [47:0] refill,
                                    logic [47:0] init, output logic clipped);
      logic [47:0] headroom;
      logic [47:0] pre;
      if (first_pending) begin
        clipped = 1'b0;
        return init;
      end
      headroom = (cap > level_after) ? cap - level_after : '0;
      clipped  = refill > headroom;
      pre      = clip_units({16'd0, level_after} + {16'd0, refill});
      return (pre > cap) ? cap : pre;
    endfunction

    // accepted picture: advance the bucket and queue the expected beat
    function void commit_picture(logic [31:0] size);
      logic [47:0]    cap;
      logic [47:0]    refill;
      logic [47:0]    init;
      logic [47:0]    pic_units;
      logic [47:0]    pre;
      logic [47:0]    next_pre;
      logic [47:0]    quo;
      logic           clipped;
      logic           next_clipped;
      bucket_result_t r;
      cap       = clip_units({32'd0, buf_size} * {48'd0, fps_num});
      refill    = clip_units({32'd0, rate} * {48'd0, fps_den});
      init      = clip_units({17'd0, cap[47:1]} + {16'd0, refill});
      if (init > cap) init = cap;
      pic_units = clip_units({32'd0, size} * {48'd0, fps_num});
      pre       = level_for(cap, refill, init, clipped);
      if (clipped) pauses = bump(pauses);
      r.underflow = pic_units > pre;
      if (r.underflow) begin
        rejects = bump(rejects);
      end else begin
        level_after = pre - pic_units;
        if (level_after < min_level) min_level = level_after;
        if (pre > max_level) max_level = pre;
        sum_bits      = clip_units({16'd0, sum_bits} + {32'd0, size});
        frames        = bump(frames);
        first_pending = 1'b0;
      end
      next_pre = level_for(cap, refill, init, next_clipped);
      quo      = (fps_num == '0) ? '0 : next_pre / {32'd0, fps_num};
      max_hint = (quo > 48'hFFFF_FFFF) ? '1 : quo[31:0];
      r.paused          = clipped;
      r.this_code       = code_of(pre, cap);
      r.after_level     = level_after;
      r.next_code       = code_of(next_pre, cap);
      r.next_max        = quo[31:0];
      r.frame_count     = frames;
      r.bits_total      = sum_bits;
      r.pause_count     = pauses;
      r.underflow_count = rejects;
      r.lowest_after    = min_level;
      r.highest_pre     = max_level;
      if (r.underflow) n_rejected++;
      if (clipped) n_clipped++;
      bucket_reports_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got_v, logic [63:0] want_v);
      mismatches++;
      if (mismatches <= PrintCap)
        $display("MISMATCH beat %0d %s: got %0h expected %0h", n_results, what, got_v, want_v);
    endtask

    task check_report(bucket_result_t got);
      bucket_result_t want;
      if (bucket_reports_q.size() == 0) begin
        report("unexpected result beat", 1, 0);
        return;
      end
      want = bucket_reports_q.pop_front();
      n_results++;
      if (got.underflow != want.underflow)
        report("underflow", got.underflow, want.underflow);
      if (got.paused != want.paused) report("paused", got.paused, want.paused);
      if (got.this_code != want.this_code)
        report("this_fullness_code", got.this_code, want.this_code);
      if (got.after_level != want.after_level)
        report("after_level", got.after_level, want.after_level);
      if (got.next_code != want.next_code)
        report("next_fullness_code", got.next_code, want.next_code);
      if (got.next_max != want.next_max)
        report("next_max_picture", got.next_max, want.next_max);
      if (got.frame_count != want.frame_count)
        report("frame_count", got.frame_count, want.frame_count);
      if (got.bits_total != want.bits_total)
        report("bits_total", got.bits_total, want.bits_total);
      if (got.pause_count != want.pause_count)
        report("pause_count", got.pause_count, want.pause_count);
      if (got.underflow_count != want.underflow_count)
        report("underflow_count", got.underflow_count, want.underflow_count);
      if (got.lowest_after != want.lowest_after)
        report("lowest_after", got.lowest_after, want.lowest_after);
      if (got.highest_pre != want.highest_pre)
        report("highest_pre", got.highest_pre, want.highest_pre);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        picture_size_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               underflow_o;
  logic               paused_o;
  logic [7:0]         this_fullness_code_o;
  logic [47:0]        after_level_o;
  logic [7:0]         next_fullness_code_o;
  logic [31:0]        next_max_picture_o;
  logic [31:0]        frame_count_o;
  logic [47:0]        bits_total_o;
  logic [31:0]        pause_count_o;
  logic [31:0]        underflow_count_o;
  logic [47:0]        lowest_after_o;
  logic [47:0]        highest_pre_o;

  bucket_scoreboard sb;
  bucket_result_t   seen;
  logic             any_beat;
  int unsigned      settings_used;

  hrd_leaky_bucket_model dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .picture_size_i       (picture_size_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .underflow_o          (underflow_o),
    .paused_o             (paused_o),
    .this_fullness_code_o (this_fullness_code_o),
    .after_level_o        (after_level_o),
    .next_fullness_code_o (next_fullness_code_o),
    .next_max_picture_o   (next_max_picture_o),
    .frame_count_o        (frame_count_o),
    .bits_total_o         (bits_total_o),
    .pause_count_o        (pause_count_o),
    .underflow_count_o    (underflow_count_o),
    .lowest_after_o       (lowest_after_o),
    .highest_pre_o        (highest_pre_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side stall pattern: calm windows, then short random stall runs
  initial begin : result_stall
    int unsigned run;
    int unsigned cycle;
    logic        hold;
    out_stall_i <= 1'b0;
    run   = 0;
    cycle = 0;
    hold  = 1'b0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (run == 0) begin
        hold = ((cycle / 1024) % 3 != 0) && !hold && ($urandom_range(0, 99) < 60);
        run  = hold ? $urandom_range(1, 12) : $urandom_range(1, 20);
      end
      run--;
      out_stall_i <= hold;
    end
  end

  // result beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.underflow       = underflow_o;
      seen.paused          = paused_o;
      seen.this_code       = this_fullness_code_o;
      seen.after_level     = after_level_o;
      seen.next_code       = next_fullness_code_o;
      seen.next_max        = next_max_picture_o;
      seen.frame_count     = frame_count_o;
      seen.bits_total      = bits_total_o;
      seen.pause_count     = pause_count_o;
      seen.underflow_count = underflow_count_o;
      seen.lowest_after    = lowest_after_o;
      seen.highest_pre     = highest_pre_o;
      sb.check_report(seen);
    end
  end

  // watchdog: too long without a beat on any channel
  assign any_beat = (cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
                    (out_valid_o && !out_stall_i);

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (any_beat) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // register write; cfg_valid_i stays high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // picture beat; in_valid_i stays high for a following picture
  task automatic put_picture(input logic [31:0] size);
    in_valid_i     <= 1'b1;
    picture_size_i <= size;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.commit_picture(size);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // hold the sender until every owed result beat is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.bucket_reports_q.size() != 0);
  endtask

  task automatic set_config(input logic [31:0] size_v, input logic [31:0] rate_v,
                            input logic [15:0] num_v, input logic [15:0] den_v);
    drain();
    write_reg(RegBufSize, size_v);
    write_reg(RegBitRate, rate_v);
    write_reg(RegFpsNum, {16'd0, num_v});
    write_reg(RegFpsDen, {16'd0, den_v});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // random settings; each register rewritten with some chance
  task automatic new_settings();
    logic [31:0] size_v;
    logic [31:0] rate_v;
    logic [31:0] junk;
    logic [63:0] wide;
    logic [15:0] num_v;
    logic [15:0] den_v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) rate_v = '1;
    else if (sel < 12) rate_v = '0;
    else if (sel < 40) rate_v = $urandom_range(1, 4096);
    else rate_v = $urandom_range(10000, 20000000);
    sel  = $urandom_range(0, 99);
    wide = {32'd0, rate_v} * $urandom_range(1, 4);
    if (sel < 8) size_v = '1;
    else if (sel < 12) size_v = '0;
    else if (sel < 35) size_v = $urandom_range(1, 8192);
    else if (sel < 60) size_v = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
    else size_v = $urandom_range(100000, 50000000);
    sel = $urandom_range(0, 99);
    if (sel < 8) num_v = '1;
    else if (sel < 11) num_v = '0;
    else if (sel < 50) begin
      case ($urandom_range(0, 5))
        0: num_v = 16'd24;
        1: num_v = 16'd25;
        2: num_v = 16'd30;
        3: num_v = 16'd60;
        4: num_v = 16'd30000;
        default: num_v = 16'd60000;
      endcase
    end else num_v = $urandom_range(1, 65535);
    sel = $urandom_range(0, 99);
    if (sel < 8) den_v = '1;
    else if (sel < 11) den_v = '0;
    else if (sel < 55) den_v = 16'd1;
    else if (sel < 70) den_v = 16'd1001;
    else den_v = $urandom_range(1, 65535);
    drain();
    // upper bits of the 16-bit registers carry junk that must be dropped
    junk = $urandom();
    if ($urandom_range(0, 3) != 0) write_reg(RegBufSize, size_v);
    if ($urandom_range(0, 3) != 0) write_reg(RegBitRate, rate_v);
    if ($urandom_range(0, 3) != 0) write_reg(RegFpsNum, {junk[31:16], num_v});
    if ($urandom_range(0, 3) != 0) write_reg(RegFpsDen, {junk[15:0], den_v});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // mostly sizes around the per-picture budget, some at the exact limit
  function automatic logic [31:0] pick_size();
    logic [63:0] budget;
    logic [63:0] v;
    int unsigned sel;
    sel    = $urandom_range(0, 99);
    budget = (sb.fps_num == '0) ? 64'd4096 :
             ({32'd0, sb.rate} * {48'd0, sb.fps_den}) / {48'd0, sb.fps_num};
    if (sel < 4) v = '0;
    else if (sel < 7) v = 64'hFFFF_FFFF;
    else if (sel < 15) v = {32'd0, $urandom()};
    else if (sel < 30) v = {32'd0, sb.max_hint} + $urandom_range(0, 1);
    else if (sel < 38) v = $urandom_range(0, 1000);
    else v = budget * $urandom_range(0, 250) / 100;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst_left;
    int unsigned phase_len;
    int unsigned k;
    sb = new();
    settings_used = 1;
    in_valid_i     <= 1'b0;
    picture_size_i <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= RegBufSize;
    cfg_data_i     <= '0;
    wait (rst_ni);
    @(posedge clk_i);

    // directed: first picture rejected under reset settings
    put_picture(32'hFFFF_FFFF);
    // zero initial level: reject, then accept a zero picture
    set_config(32'd1, 32'd0, 16'd1, 16'd1);
    put_picture(32'd1);
    put_picture(32'd0);
    set_config(BufSizeRst, BitRateRst, FpsNumRst, FpsDenRst);
    put_picture(32'd0);
    put_picture(32'd400000);
    put_picture(32'd600000);
    put_picture(32'd17476);
    put_picture(32'd17477);
    // small bucket: clipped refills, pause on a rejected picture
    set_config(32'd1000, 32'd800, 16'd1, 16'd1);
    put_picture(32'd0);
    put_picture(32'd0);
    put_picture(32'd5000);
    put_picture(32'd1000);
    put_picture(32'd0);
    // level above a shrunk buffer, with and without refill
    set_config(32'd10, 32'd0, 16'd1, 16'd1);
    put_picture(32'd4);
    set_config(32'd1000, 32'd800, 16'd1, 16'd1);
    put_picture(32'd0);
    set_config(32'd10, 32'd800, 16'd1, 16'd1);
    put_picture(32'd4);
    // zero registers
    set_config(32'd5000, 32'd700, 16'd0, 16'd0);
    put_picture(32'hFFFF_FFFF);
    put_picture(32'd1);
    set_config(32'd0, 32'd700, 16'd1, 16'd1);
    put_picture(32'd0);
    // largest settings: largest unit products
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    put_picture(32'hFFFF_FFFF);
    put_picture(32'hFFFF_FFFF);
    put_picture(32'd0);

    // random phases, each under fresh settings
    sent = 0;
    while (sent < RandomPictures) begin
      new_settings();
      phase_len  = $urandom_range(60, 130);
      burst_left = 0;
      for (k = 0; k < phase_len; k++) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
                                                     $urandom_range(1, 8);
          if (k != 0) pause_sender($urandom_range(1, 120));
        end
        if ($urandom_range(0, 49) == 0) drain();
        put_picture(pick_size());
        burst_left--;
      end
      sent += phase_len;
    end

    // wind down
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.bucket_reports_q.size() != 0)
      sb.report("result beats missing", sb.bucket_reports_q.size(), 0);
    $display("Covered %0d pictures under %0d register settings: %0d rejected, %0d clipped.",
             sb.n_results, settings_used, sb.n_rejected, sb.n_clipped);
    $display("Sender bursts and gaps, result stalls; %0d field mismatches.", sb.mismatches);
    if (sb.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
